/* hdl/frame_bitmap_allocator_top_macros.svh */
// Assertion macros for the frame bitmap allocator.
// Used by the checker; expects clk and rst_n in the scope of use.
`ifndef FRAME_BITMAP_ALLOCATOR_TOP_MACROS_SVH
`define FRAME_BITMAP_ALLOCATOR_TOP_MACROS_SVH

// Checked outside reset.
`define FBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked on every edge, reset included.
`define FBA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/fba_pkg.sv */
// Shared types and constants for the frame bitmap allocator.
// No dependencies; every file but fba_ram and the macro header imports it.
package fba_pkg;

  localparam int FRAME_COUNT  = 4096;
  localparam int FRAME_W      = 12;
  localparam int WORD_W       = 32;
  localparam int BIT_W        = 5;
  localparam int BITMAP_WORDS = FRAME_COUNT / WORD_W;
  // new_frame only reaches this many words
  localparam int FIELD_WORDS  = 1 << (FRAME_W - BIT_W);
  localparam int MEM_WORDS    = (BITMAP_WORDS < FIELD_WORDS) ? BITMAP_WORDS : FIELD_WORDS;
  localparam int ADDR_W       = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    STAT_DONE      = 2'd0,
    STAT_NO_ACTION = 2'd1,
    STAT_NO_FRAME  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SET,
    S_CLR,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [FRAME_W-1:0] new_frame;
    logic               present_bit;
    logic               write_bit;
    logic               user_bit;
    status_t            status;
  } rsp_t;

  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic             all_ones;
    logic [BIT_W-1:0] idx;
  } ffz_res_t;

endpackage

/* hdl/fba_if.sv */
// Valid/ready channel interfaces for requests and results.
// Depends on fba_pkg for field widths.
interface fba_in_if;
  import fba_pkg::*;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [FRAME_W-1:0] current_frame;
  logic               kernel_page;
  logic               writeable_page;

  modport source (output valid, opcode, current_frame, kernel_page, writeable_page,
                  input ready);
  modport sink   (input valid, opcode, current_frame, kernel_page, writeable_page,
                  output ready);
endinterface

interface fba_out_if;
  import fba_pkg::*;
  logic               valid;
  logic               ready;
  logic [FRAME_W-1:0] new_frame;
  logic               present_bit;
  logic               write_bit;
  logic               user_bit;
  logic [1:0]         status;

  modport source (output valid, new_frame, present_bit, write_bit, user_bit, status,
                  input ready);
  modport sink   (input valid, new_frame, present_bit, write_bit, user_bit, status,
                  output ready);
endinterface

/* hdl/fba_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/fba_ffz.sv */
// Find-first-zero unit: lowest clear bit of one bitmap word.
// Depends on fba_pkg.
module fba_ffz (
  input  logic [fba_pkg::WORD_W-1:0] word,
  output fba_pkg::ffz_res_t          res
);
  import fba_pkg::*;

  always_comb begin
    res.all_ones = &word;
    res.idx      = '0;
    // scan high to low so the lowest clear bit wins
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!word[i]) begin
        res.idx = BIT_W'(i);
      end
    end
  end

endmodule

/* hdl/fba_seq.sv */
// Sequencer: request decode, bitmap word scan, read-modify-write and
// the result register. Depends on fba_pkg, fba_if and fba_ffz.
module fba_seq (
  input  logic                       clk,
  input  logic                       rst_n,
  fba_in_if.sink                     in_chan,
  fba_out_if.source                  out_chan,
  output fba_pkg::mem_req_t          mem_req,
  input  logic [fba_pkg::WORD_W-1:0] mem_rdata
);
  import fba_pkg::*;

  state_t             state_r, state_nxt;
  logic [ADDR_W-1:0]  rd_addr_r, rd_addr_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic [ADDR_W-1:0]  wr_addr_r, wr_addr_nxt;
  logic [WORD_W-1:0]  wr_data_r, wr_data_nxt;
  logic [MEM_WORDS-1:0] vld_r, vld_nxt;
  logic [FRAME_W-1:0] cur_r;
  logic               kern_r;
  logic               wrt_r;
  rsp_t               rsp_r, rsp_nxt;
  rsp_t               out_r;
  logic               out_valid_r;

  logic                    acc;
  logic                    in_alloc;
  logic                    in_cur_zero;
  logic [FRAME_W-BIT_W-1:0] in_word;
  logic                    in_range;
  logic [WORD_W-1:0]       eff_word;
  ffz_res_t                ffz_res;
  logic                    scan_last;
  logic                    out_free;
  logic                    out_load;

  assign acc         = in_chan.valid && in_chan.ready;
  assign in_alloc    = (opcode_t'(in_chan.opcode) == OP_ALLOC);
  assign in_cur_zero = (in_chan.current_frame == '0);
  assign in_word     = in_chan.current_frame[FRAME_W-1:BIT_W];
  assign in_range    = (int'(in_word) < BITMAP_WORDS);
  // never-written words read as free
  assign eff_word    = rd_vld_r ? mem_rdata : '0;
  assign scan_last   = (rd_addr_r == ADDR_W'(MEM_WORDS - 1));
  assign out_free    = !out_valid_r || out_chan.ready;

  fba_ffz u_ffz (
    .word (eff_word),
    .res  (ffz_res)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (in_alloc) begin
            state_nxt = in_cur_zero ? S_SCAN : S_RESP;
          end else begin
            state_nxt = (!in_cur_zero && in_range) ? S_CLR : S_RESP;
          end
        end
      end
      S_SCAN: begin
        if (!ffz_res.all_ones) begin
          state_nxt = S_SET;
        end else if (scan_last) begin
          state_nxt = S_RESP;
        end
      end
      S_SET:  state_nxt = S_RESP;
      S_CLR:  state_nxt = S_RESP;
      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_chan.ready = 1'b0;
    mem_req       = '0;
    rd_addr_nxt   = rd_addr_r;
    rd_vld_nxt    = rd_vld_r;
    wr_addr_nxt   = wr_addr_r;
    wr_data_nxt   = wr_data_r;
    vld_nxt       = vld_r;
    rsp_nxt       = rsp_r;
    out_load      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_chan.ready = 1'b1;
        if (acc) begin
          rsp_nxt        = '0;
          rsp_nxt.status = STAT_NO_ACTION;
          if (in_alloc) begin
            if (in_cur_zero) begin
              mem_req.re    = 1'b1;
              mem_req.raddr = '0;
              rd_addr_nxt   = '0;
              rd_vld_nxt    = vld_r[0];
            end else begin
              rsp_nxt.new_frame = in_chan.current_frame;
            end
          end else if (!in_cur_zero) begin
            rsp_nxt.status = STAT_DONE;
            if (in_range) begin
              mem_req.re    = 1'b1;
              mem_req.raddr = in_word[ADDR_W-1:0];
              rd_addr_nxt   = in_word[ADDR_W-1:0];
              rd_vld_nxt    = vld_r[in_word[ADDR_W-1:0]];
            end
          end
        end
      end
      S_SCAN: begin
        if (!ffz_res.all_ones) begin
          wr_addr_nxt         = rd_addr_r;
          wr_data_nxt         = eff_word | (WORD_W'(1) << ffz_res.idx);
          rsp_nxt.new_frame   = FRAME_W'({rd_addr_r, ffz_res.idx});
          rsp_nxt.present_bit = 1'b1;
          rsp_nxt.write_bit   = wrt_r;
          rsp_nxt.user_bit    = !kern_r;
          rsp_nxt.status      = STAT_DONE;
        end else if (scan_last) begin
          rsp_nxt        = '0;
          rsp_nxt.status = STAT_NO_FRAME;
        end else begin
          // one word per cycle, data returns next cycle
          mem_req.re    = 1'b1;
          mem_req.raddr = rd_addr_r + 1'b1;
          rd_addr_nxt   = rd_addr_r + 1'b1;
          rd_vld_nxt    = vld_r[rd_addr_r + 1'b1];
        end
      end
      S_SET: begin
        mem_req.we         = 1'b1;
        mem_req.waddr      = wr_addr_r;
        mem_req.wdata      = wr_data_r;
        vld_nxt[wr_addr_r] = 1'b1;
      end
      S_CLR: begin
        mem_req.we         = 1'b1;
        mem_req.waddr      = rd_addr_r;
        mem_req.wdata      = eff_word & ~(WORD_W'(1) << cur_r[BIT_W-1:0]);
        vld_nxt[rd_addr_r] = 1'b1;
      end
      S_RESP: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vld_r   <= vld_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r <= rd_addr_nxt;
    rd_vld_r  <= rd_vld_nxt;
    wr_addr_r <= wr_addr_nxt;
    wr_data_r <= wr_data_nxt;
    rsp_r     <= rsp_nxt;
    if (acc) begin
      cur_r  <= in_chan.current_frame;
      kern_r <= in_chan.kernel_page;
      wrt_r  <= in_chan.writeable_page;
    end
    if (out_load) begin
      out_r <= rsp_r;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.new_frame   = out_r.new_frame;
  assign out_chan.present_bit = out_r.present_bit;
  assign out_chan.write_bit   = out_r.write_bit;
  assign out_chan.user_bit    = out_r.user_bit;
  assign out_chan.status      = out_r.status;

endmodule

/* hdl/frame_bitmap_allocator_top.sv */
// Channel    | Dir | Handshake    | Contents
// in_chan    | in  | valid/ready  | opcode, current_frame, kernel_page, writeable_page
// out_chan   | out | valid/ready  | new_frame, present_bit, write_bit, user_bit, status
//
// One request at a time. Allocate with current_frame 0 scans the bitmap RAM one
// 32-bit word per cycle and writes the hit word back in S_SET, or reports no frame
// when all 128 words are full. Free clears its bit in S_CLR; all results pass S_RESP.
// Reset clears per-word valid bits, so the bitmap reads free at once; no sweep.
// A stalled result holds in the output register; the next request is still taken,
// and its result waits in S_RESP until that register frees.
module frame_bitmap_allocator_top (
  input  logic      clk,
  input  logic      rst_n,
  fba_in_if.sink    in_chan,
  fba_out_if.source out_chan
);
  import fba_pkg::*;

  mem_req_t          mem_req;
  logic [WORD_W-1:0] mem_rdata;

  fba_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  fba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MEM_WORDS),
    .AW    (ADDR_W)
  ) u_bitmap (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

endmodule

/* hdl/fba_checker.sv */
// Port-level checks for the frame bitmap allocator, bound to the top level.
// Depends on fba_pkg and frame_bitmap_allocator_top_macros.svh.
`include "frame_bitmap_allocator_top_macros.svh"

module fba_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [fba_pkg::FRAME_W-1:0] out_new_frame,
  input logic                        out_present_bit,
  input logic                        out_write_bit,
  input logic                        out_user_bit,
  input logic [1:0]                  out_status
);
  import fba_pkg::*;

  `FBA_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `FBA_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "second request taken while busy")
  `FBA_ASSERT(a_full_clean, out_valid && (out_status == STAT_NO_FRAME) |-> (out_new_frame == '0) && !out_present_bit && !out_write_bit && !out_user_bit, "no-frame result carries data")
  `FBA_ASSERT(a_present_done, out_valid && out_present_bit |-> (out_status == STAT_DONE), "present frame without done status")
  `FBA_ASSERT_RST(a_reset_idle, !rst_n |=> !out_valid, "result valid out of reset")

endmodule

bind frame_bitmap_allocator_top fba_checker u_fba_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_new_frame   (out_chan.new_frame),
  .out_present_bit (out_chan.present_bit),
  .out_write_bit   (out_chan.write_bit),
  .out_user_bit    (out_chan.user_bit),
  .out_status      (out_chan.status)
);

/* sim/frame_bitmap_allocator_top_test.sv */
// Self-checking testbench for frame_bitmap_allocator_top: directed, random, stall and
// free/reclaim traffic, each result checked against an in-bench bitmap predictor.
// Depends on fba_pkg, fba_in_if/fba_out_if and the allocator RTL.
module frame_bitmap_allocator_top_test;
  import fba_pkg::*;

  typedef enum {RX_OPEN, RX_RANDOM, RX_PERIODIC} rx_pattern_t;

  localparam int TRACKED_FRAMES = MEM_WORDS * WORD_W;

  logic clk;
  logic rst_n;

  fba_in_if  in_chan();
  fba_out_if out_chan();

  frame_bitmap_allocator_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan.sink),
    .out_chan(out_chan.source)
  );

  // predicted allocator state, one bit per frame
  logic [WORD_W-1:0] frame_bitmap [MEM_WORDS];
  rsp_t              pending_entries [$];

  int errors        = 0;
  int checked_count = 0;
  int grant_count   = 0;
  int free_count    = 0;
  int refused_count = 0;
  int burst_left    = 0;
  int holdoff_cycles = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #50_000_000;
    $display("frame_bitmap_allocator_top_test failed");
    $finish;
  end

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic rsp_t predict_entry(input opcode_t op, input logic [FRAME_W-1:0] cur,
                                         input logic kern, input logic wr);
    rsp_t r;
    int   w;
    int   b;
    bit   found;
    r = '0;
    r.status = STAT_DONE;
    found = 1'b0;
    if (op == OP_ALLOC) begin
      if (cur != '0) begin
        r.new_frame = cur;
        r.status = STAT_NO_ACTION;
      end else begin
        for (w = 0; w < MEM_WORDS && !found; w++) begin
          if (frame_bitmap[w] != '1) begin
            for (b = 0; b < WORD_W && !found; b++) begin
              if (!frame_bitmap[w][b]) begin
                found = 1'b1;
                frame_bitmap[w][b] = 1'b1;
                r.new_frame   = FRAME_W'(w * WORD_W + b);
                r.present_bit = 1'b1;
                r.write_bit   = wr;
                r.user_bit    = ~kern;
              end
            end
          end
        end
        if (found) grant_count++;
        else begin
          r.status = STAT_NO_FRAME;
          refused_count++;
        end
      end
    end else if (cur == '0) begin
      r.status = STAT_NO_ACTION;
    end else begin
      // frames past the bitmap are silently ignored
      if ((cur >> BIT_W) < MEM_WORDS) frame_bitmap[cur >> BIT_W][cur[BIT_W-1:0]] = 1'b0;
      free_count++;
    end
    return r;
  endfunction

  // some in-use frame other than 0 (frame 0 can never be freed), or 0 if none
  function automatic int pick_used_frame();
    int start;
    int k;
    int f;
    start = $urandom_range(1, TRACKED_FRAMES - 1);
    for (k = 0; k < TRACKED_FRAMES; k++) begin
      f = (start + k) % TRACKED_FRAMES;
      if (f != 0 && frame_bitmap[f / WORD_W][f % WORD_W]) return f;
    end
    return 0;
  endfunction

  // Drive one request; bursts of back-to-back transactions separated by idle gaps.
  task automatic send_request(input opcode_t op, input logic [FRAME_W-1:0] cur,
                              input logic kern, input logic wr);
    if (burst_left == 0) begin
      if ($urandom_range(0, 5) == 0) repeat ($urandom_range(10, 30)) @(posedge clk);
      else repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 100) : $urandom_range(1, 10);
    end
    in_chan.valid          <= 1'b1;
    in_chan.opcode         <= op;
    in_chan.current_frame  <= cur;
    in_chan.kernel_page    <= kern;
    in_chan.writeable_page <= wr;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    pending_entries.push_back(predict_entry(op, cur, kern, wr));
    burst_left--;
    if (burst_left == 0) in_chan.valid <= 1'b0;
  endtask

  task automatic wait_all_results();
    if (burst_left > 0) begin
      in_chan.valid <= 1'b0;
      burst_left = 0;
    end
    while (pending_entries.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input int expv, input int actv);
    if (expv != actv) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
      errors++;
    end
  endtask

  // Result side: check each transaction, then pick next ready from the stall pattern.
  initial begin
    rx_pattern_t pattern;
    int          pattern_left;
    int          hold_left;
    int          phase;
    rsp_t        expd;
    pattern      = RX_OPEN;
    pattern_left = 0;
    hold_left    = 0;
    phase        = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_chan.valid && out_chan.ready) begin
        if (pending_entries.size() == 0) begin
          $display("%0t: result with nothing expected, frame %0d status %0d", $time,
                   out_chan.new_frame, out_chan.status);
          errors++;
        end else begin
          expd = pending_entries.pop_front();
          check_field("new_frame", expd.new_frame, out_chan.new_frame);
          check_field("present_bit", expd.present_bit, out_chan.present_bit);
          check_field("write_bit", expd.write_bit, out_chan.write_bit);
          check_field("user_bit", expd.user_bit, out_chan.user_bit);
          check_field("status", expd.status, out_chan.status);
          checked_count++;
        end
      end
      if (holdoff_cycles > 0) begin
        hold_left = holdoff_cycles;
        holdoff_cycles = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        if (pattern_left == 0) begin
          case ($urandom_range(0, 2))
            0: pattern = RX_OPEN;
            1: pattern = RX_RANDOM;
            default: pattern = RX_PERIODIC;
          endcase
          pattern_left = $urandom_range(5, 60);
        end
        pattern_left--;
        phase++;
        case (pattern)
          RX_OPEN:   out_chan.ready <= 1'b1;
          RX_RANDOM: out_chan.ready <= ($urandom_range(0, 1) == 1);
          default:   out_chan.ready <= (phase % 3 != 0);
        endcase
      end
    end
  end

  task automatic test_directed_requests();
    send_request(OP_ALLOC, '0, 1'b0, 1'b1);       // first grant is frame 0, which can never be freed
    send_request(OP_ALLOC, '0, 1'b1, 1'b0);
    send_request(OP_ALLOC, '0, 1'b1, 1'b1);
    send_request(OP_ALLOC, '0, 1'b0, 1'b0);
    send_request(OP_ALLOC, 12'd4095, 1'b1, 1'b1); // page already mapped
    send_request(OP_ALLOC, 12'd1, 1'b0, 1'b0);
    send_request(OP_ALLOC, 12'hAAA, 1'b1, 1'b0);
    send_request(OP_ALLOC, 12'h555, 1'b0, 1'b1);
    send_request(OP_FREE, '0, 1'b1, 1'b1);        // nothing mapped: no action
    send_request(OP_FREE, '0, 1'b0, 1'b0);
    send_request(OP_FREE, 12'd1, 1'b1, 1'b1);
    send_request(OP_ALLOC, '0, 1'b1, 1'b1);       // reclaims frame 1
    send_request(OP_FREE, 12'd4095, 1'b0, 1'b1);  // never allocated
    send_request(OP_FREE, 12'd2, 1'b0, 1'b0);
    send_request(OP_FREE, 12'd2, 1'b1, 1'b0);     // already free
    send_request(OP_FREE, 12'hFFE, 1'b0, 1'b0);
    send_request(OP_ALLOC, '0, 1'b0, 1'b1);
    send_request(OP_ALLOC, '0, 1'b1, 1'b0);
    send_request(OP_FREE, 12'd3, 1'b1, 1'b1);
    send_request(OP_ALLOC, '0, 1'b0, 1'b0);
    wait_all_results();
  endtask

  // Receiver holds off while requests keep coming, so the input must stall.
  task automatic test_output_holdoff();
    holdoff_cycles = 300;
    repeat (10) begin
      if ($urandom_range(0, 2) == 0)
        send_request(OP_FREE, 12'(pick_used_frame()), rand_bit(), rand_bit());
      else
        send_request(OP_ALLOC, '0, rand_bit(), rand_bit());
    end
    wait_all_results();
  endtask

  task automatic test_random_traffic();
    int i;
    int sel;
    int f;
    for (i = 0; i < 1050; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        send_request(OP_ALLOC, '0, rand_bit(), rand_bit());
      end else if (sel < 75) begin
        f = pick_used_frame();
        if (f == 0) f = $urandom_range(1, 4095);
        send_request(OP_FREE, 12'(f), rand_bit(), rand_bit());
      end else if (sel < 85) begin
        send_request(OP_ALLOC, 12'($urandom_range(1, 4095)), rand_bit(), rand_bit());
      end else if (sel < 93) begin
        send_request(OP_FREE, 12'($urandom_range(0, 4095)), rand_bit(), rand_bit());
      end else begin
        send_request(OP_FREE, '0, rand_bit(), rand_bit());
      end
    end
    wait_all_results();
  endtask

  // Free frames at word edges and deep in the map, then reclaim them.
  task automatic test_reclaim();
    int f;
    send_request(OP_FREE, 12'd4095, 1'b0, 1'b1);
    send_request(OP_FREE, 12'd31, 1'b1, 1'b0);
    send_request(OP_FREE, 12'd32, 1'b0, 1'b0);
    repeat (2) send_request(OP_ALLOC, '0, rand_bit(), rand_bit());
    repeat (40) begin
      f = pick_used_frame();
      send_request(OP_FREE, 12'(f), rand_bit(), rand_bit());
      send_request(OP_ALLOC, '0, rand_bit(), rand_bit());
    end
    wait_all_results();
  endtask

  initial begin
    int w;
    for (w = 0; w < MEM_WORDS; w++) frame_bitmap[w] = '0;
    rst_n                  <= 1'b0;
    in_chan.valid          <= 1'b0;
    in_chan.opcode         <= OP_ALLOC;
    in_chan.current_frame  <= '0;
    in_chan.kernel_page    <= 1'b0;
    in_chan.writeable_page <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_requests();
    test_output_holdoff();
    test_random_traffic();
    test_reclaim();

    wait_all_results();
    repeat (150) @(posedge clk);
    $display("Checked %0d results: %0d frames granted, %0d frees, %0d refusals on a full bitmap",
             checked_count, grant_count, free_count, refused_count);
    $display("Traffic covered directed cases, output holdoff, random mixes and frame reclaim");
    if (errors == 0) $display("frame_bitmap_allocator_top_test passed");
    else $display("frame_bitmap_allocator_top_test failed");
    $finish;
  end

endmodule
